FILE: hdl/ble_advert_device_matcher_core_defines.svh
// -----------------------------------------------------------------------------
// Advertising matcher assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef BLE_ADVERT_DEVICE_MATCHER_CORE_DEFINES_SVH
`define BLE_ADVERT_DEVICE_MATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BDM_ASSERT_NOW(lbl, ante, cons)
`define BDM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/bdm_pkg.sv
// -----------------------------------------------------------------------------
// Advertising matcher package
// Request and result types, register constants and the name prefix tables.
// -----------------------------------------------------------------------------
package bdm_pkg;

  localparam int CFG_REGS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Reset value of the UUID registers, word 0 in the low 32 bits.
  localparam logic [CFG_REGS-1:0][CFG_DATA_W-1:0] UUID_RST = {
    32'h0783_B03E, 32'h8535_B5A0, 32'h7140_A304, 32'hD249_5CB7
  };

  // Advertising data element types.
  localparam logic [7:0] AD_UUID128_PART  = 8'h06;
  localparam logic [7:0] AD_UUID128_ALL   = 8'h07;
  localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
  localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam int PFX_NUM    = 5;
  localparam int PFX_MAXLEN = 10;

  localparam logic [7:0] PFX_LEN [PFX_NUM] = '{8'd4, 8'd3, 8'd3, 8'd10, 8'd6};

  // Prefix text, character 0 in bits 7:0, upper case.
  localparam logic [8*PFX_MAXLEN-1:0] PFX_TEXT [PFX_NUM] = '{
    80'h0000_0000_0000_4F47_4E45,
    80'h0000_0000_0000_002D_4C41,
    80'h0000_0000_0000_0020_4C41,
    80'h4B4F_4F4C_4556_4954_4341,
    80'h0000_0000_4B4F_4F4C_2E41
  };

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
  } bdm_in_t;

  typedef struct packed {
    logic       parse_ok;
    logic       uuid_found;
    logic       prefix_found;
    logic       serial_valid;
    logic [3:0] char_index;
    logic [7:0] name_char;
    logic [7:0] serial_char;
    logic       run_end;
  } bdm_out_t;

  // Summary of one finished payload, handed to the result sequencer.
  typedef struct packed {
    logic ok;
    logic uuid;
    logic prefix;
    logic serial;
  } bdm_flags_t;

  // Prefixes that are no longer than an element of n data bytes.
  function automatic logic [PFX_NUM-1:0] pfx_fit(input logic [7:0] n);
    logic [PFX_NUM-1:0] r;
    r = '0;
    for (int i = 0; i < PFX_NUM; i++) begin
      r[i] = (PFX_LEN[i] <= n);
    end
    return r;
  endfunction

  // Prefixes that disagree with folded character c at data position p.
  function automatic logic [PFX_NUM-1:0] pfx_miss(input logic [7:0] c,
                                                  input logic [7:0] p);
    logic [PFX_NUM-1:0] r;
    r = '0;
    for (int i = 0; i < PFX_NUM; i++) begin
      if (p < PFX_LEN[i]) begin
        r[i] = (c != PFX_TEXT[i][8*p[3:0] +: 8]);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      r = b - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: hdl/bdm_ram.sv
// -----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// -----------------------------------------------------------------------------
module bdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bdm_emit.sv
// -----------------------------------------------------------------------------
// Advertising matcher result sequencer
// Reads one kept name out of the name memory and streams the per-character
// results through a read stage and an output register.
// -----------------------------------------------------------------------------
`include "ble_advert_device_matcher_core_defines.svh"

module bdm_emit #(
  parameter int NAME_LEN   = 16,
  parameter int SERIAL_LEN = 6,
  parameter int IDX_W      = 4,
  parameter int NL_W       = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bdm_pkg::bdm_flags_t  flags_i,
  input  logic [NL_W-1:0]      name_len_i,
  input  logic                 bank_i,
  input  logic [7:0]           serial_i [SERIAL_LEN],
  output logic                 busy_o,
  output logic                 rd_en_o,
  output logic [IDX_W:0]       rd_addr_o,
  input  logic [7:0]           rd_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bdm_pkg::bdm_out_t    out_o
);
  import bdm_pkg::*;

  localparam int SER_W = (SERIAL_LEN > 1) ? $clog2(SERIAL_LEN) : 1;

  logic             busy_q;
  logic [IDX_W-1:0] cnt_q;
  bdm_flags_t       flags_q;
  logic [NL_W-1:0]  len_q;
  logic             bank_q;
  logic [7:0]       ser_q [SERIAL_LEN];

  logic             s1_valid_q;
  bdm_out_t         s1_q;
  logic             s1_name_en_q;
  logic             out_valid_q;
  bdm_out_t         out_q;

  logic             s2_free;
  logic             s1_adv;
  logic             issue;
  logic             last;
  logic [SER_W-1:0] sidx;
  bdm_out_t         s1_d;

  assign s2_free = !out_valid_q || out_ready_i;
  assign s1_adv  = s1_valid_q && s2_free;
  // The RAM read register only moves when the read stage is free to take it.
  assign issue   = busy_q && (!s1_valid_q || s1_adv);
  assign last    = (cnt_q == IDX_W'(NAME_LEN - 1));
  assign sidx    = SER_W'(cnt_q);

  assign busy_o      = busy_q;
  assign rd_en_o     = issue;
  assign rd_addr_o   = {bank_q, cnt_q};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    s1_d              = '0;
    s1_d.parse_ok     = flags_q.ok;
    s1_d.uuid_found   = flags_q.ok && flags_q.uuid;
    s1_d.prefix_found = flags_q.ok && flags_q.prefix;
    s1_d.serial_valid = flags_q.ok && flags_q.serial;
    s1_d.char_index   = 4'(cnt_q);
    if (flags_q.ok && flags_q.serial && (32'(cnt_q) < SERIAL_LEN)) begin
      s1_d.serial_char = ser_q[sidx];
    end
    s1_d.run_end = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (issue) begin
        if (last) begin
          busy_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end

      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flags_q <= flags_i;
      len_q   <= name_len_i;
      bank_q  <= bank_i;
      ser_q   <= serial_i;
    end
    if (issue) begin
      s1_q         <= s1_d;
      s1_name_en_q <= flags_q.ok && (NL_W'(cnt_q) < len_q);
    end
    if (s1_adv) begin
      out_q           <= s1_q;
      out_q.name_char <= s1_name_en_q ? rd_data_i : 8'h00;
    end
  end

  `BDM_ASSERT_NOW(a_start_idle, start_i, !busy_q)
  `BDM_ASSERT_NOW(a_run_end_idx, out_valid_o && out_o.run_end, out_o.char_index == 4'(NAME_LEN - 1))
  `BDM_ASSERT_NOW(a_no_read_stall, s1_valid_q && !s2_free, !rd_en_o)

endmodule

FILE: hdl/ble_advert_device_matcher_core.sv
// -----------------------------------------------------------------------------
// Advertising payload device matcher
// Takes one payload byte per cycle and walks the length/type/data elements.
// Element state sits in registers, the kept name in a two-bank name memory so
// that one payload's name can be read out while the next payload is parsed.
// On the byte marked final, NAME_LEN results follow at one per cycle while out_ready_i
// stays high, each passing through the read stage and the output register. A final byte
// is held off while the previous payload's results are still being read from the name
// memory, so a payload shorter than NAME_LEN bytes can wait for its final byte; all other
// bytes go in every cycle.
// -----------------------------------------------------------------------------
`include "ble_advert_device_matcher_core_defines.svh"

module ble_advert_device_matcher_core #(
  parameter int NAME_LEN   = 16,
  parameter int SERIAL_LEN = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bdm_pkg::bdm_in_t                 in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bdm_pkg::bdm_out_t                out_o,
  input  logic                             cfg_we_i,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bdm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bdm_pkg::*;

  localparam int IDX_W  = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam int NL_W   = $clog2(NAME_LEN + 1);
  localparam int ADDR_W = IDX_W + 1;

  typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_DATA, PH_STOP} phase_e;
  typedef enum logic [1:0] {K_OTHER, K_UUID, K_SHORT, K_FULL} kind_e;

  logic [CFG_REGS-1:0][CFG_DATA_W-1:0] uuid_q;

  phase_e              phase_q, phase_d;
  logic [7:0]          rem_q, rem_d;
  kind_e               kind_q, kind_d;
  logic [7:0]          pos_q, pos_d;
  logic [NL_W-1:0]     name_len_q, name_len_d;
  logic                uuid_flag_q, uuid_flag_d;
  logic                pfx_flag_q, pfx_flag_d;
  logic                ser_flag_q, ser_flag_d;
  logic                copy_q, copy_d;
  logic                chunk_q, chunk_d;
  logic [PFX_NUM-1:0]  pmatch_q, pmatch_d;
  logic [7:0]          name0_q, name0_d;
  logic                bank_q, bank_d;
  logic [7:0]          shift_q [SERIAL_LEN];
  logic [7:0]          shift_d [SERIAL_LEN];
  logic [7:0]          sstore_q [SERIAL_LEN];
  logic [7:0]          sstore_d [SERIAL_LEN];

  logic                in_acc;
  logic                emit_busy;
  logic                start;
  bdm_flags_t          job_flags;
  logic [NL_W-1:0]     job_len;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          rd_data;

  // Only a final byte has to wait for the name memory bank to come free.
  assign in_ready_o = !(emit_busy && in_i.final_byte);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && in_i.final_byte;

  assign ram_we    = in_acc && (phase_q == PH_DATA) && (kind_q == K_SHORT || kind_q == K_FULL)
                     && copy_q && (pos_q < 8'(NAME_LEN));
  assign ram_waddr = {bank_q, pos_q[IDX_W-1:0]};

  always_comb begin
    logic [7:0] b;
    logic [7:0] n;
    logic [3:0] q;
    logic       fin_elem;

    b        = in_i.payload_byte;
    n        = rem_q - 8'd1;
    q        = pos_q[3:0];
    fin_elem = 1'b0;

    phase_d     = phase_q;
    rem_d       = rem_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    name_len_d  = name_len_q;
    uuid_flag_d = uuid_flag_q;
    pfx_flag_d  = pfx_flag_q;
    ser_flag_d  = ser_flag_q;
    copy_d      = copy_q;
    chunk_d     = chunk_q;
    pmatch_d    = pmatch_q;
    name0_d     = name0_q;
    bank_d      = bank_q;
    shift_d     = shift_q;
    sstore_d    = sstore_q;

    if (in_acc) begin
      unique case (phase_q)
        PH_LEN: begin
          if (b == 8'h00) begin
            phase_d = PH_STOP;
          end else begin
            rem_d   = b;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          rem_d    = n;
          pos_d    = 8'h00;
          chunk_d  = 1'b0;
          pmatch_d = '0;
          copy_d   = 1'b0;
          priority if (b == AD_UUID128_PART || b == AD_UUID128_ALL) begin
            kind_d = K_UUID;
          end else if (b == AD_NAME_SHORT) begin
            kind_d = K_SHORT;
          end else if (b == AD_NAME_COMPLETE) begin
            kind_d = K_FULL;
          end else begin
            kind_d = K_OTHER;
          end
          if (kind_d == K_SHORT || kind_d == K_FULL) begin
            pmatch_d = pfx_fit(n);
            // A shortened name only fills an empty slot or one whose first byte is zero; a complete one always wins.
            if (kind_d == K_FULL || name_len_q == '0 || name0_q == 8'h00) begin
              copy_d     = 1'b1;
              name_len_d = (n < 8'(NAME_LEN)) ? NL_W'(n) : NL_W'(NAME_LEN);
            end
          end
          if (n == 8'h00) begin
            fin_elem = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (kind_q == K_UUID) begin
            chunk_d = (q == 4'd0) ? 1'b1 : chunk_q;
            if (b != uuid_q[q[3:2]][8*q[1:0] +: 8]) begin
              chunk_d = 1'b0;
            end
            if (q == 4'd15 && chunk_d) begin
              uuid_flag_d = 1'b1;
            end
          end else if (kind_q != K_OTHER) begin
            if (ram_we && pos_q == 8'h00) begin
              name0_d = b;
            end
            for (int j = 0; j < SERIAL_LEN - 1; j++) begin
              shift_d[j] = shift_q[j+1];
            end
            shift_d[SERIAL_LEN-1] = b;
            pmatch_d = pmatch_q & ~pfx_miss(fold_upper(b), pos_q);
          end
          if (pos_q != 8'hFF) begin
            pos_d = pos_q + 8'd1;
          end
          rem_d = rem_q - 8'd1;
          if (rem_d == 8'h00) begin
            fin_elem = 1'b1;
          end
        end
        PH_STOP: begin
        end
        default: begin
        end
      endcase

      if (fin_elem) begin
        if (kind_d == K_FULL && pos_d >= 8'(SERIAL_LEN)) begin
          sstore_d   = shift_d;
          ser_flag_d = 1'b1;
        end
        if ((kind_d == K_FULL || kind_d == K_SHORT) && pmatch_d != '0) begin
          pfx_flag_d = 1'b1;
        end
        phase_d = PH_LEN;
      end
    end

    // Snapshot of the finished payload before the run state is cleared.
    job_flags.ok     = !(phase_d == PH_TYPE || phase_d == PH_DATA);
    job_flags.uuid   = uuid_flag_d;
    job_flags.prefix = pfx_flag_d;
    job_flags.serial = ser_flag_d;
    job_len          = name_len_d;

    if (start) begin
      phase_d     = PH_LEN;
      rem_d       = 8'h00;
      kind_d      = K_OTHER;
      pos_d       = 8'h00;
      name_len_d  = '0;
      uuid_flag_d = 1'b0;
      pfx_flag_d  = 1'b0;
      ser_flag_d  = 1'b0;
      copy_d      = 1'b0;
      chunk_d     = 1'b0;
      pmatch_d    = '0;
      bank_d      = !bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_q      <= UUID_RST;
      phase_q     <= PH_LEN;
      rem_q       <= 8'h00;
      kind_q      <= K_OTHER;
      pos_q       <= 8'h00;
      name_len_q  <= '0;
      uuid_flag_q <= 1'b0;
      pfx_flag_q  <= 1'b0;
      ser_flag_q  <= 1'b0;
      copy_q      <= 1'b0;
      chunk_q     <= 1'b0;
      pmatch_q    <= '0;
      name0_q     <= 8'h00;
      bank_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        uuid_q[cfg_index_i] <= cfg_data_i;
      end
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      name_len_q  <= name_len_d;
      uuid_flag_q <= uuid_flag_d;
      pfx_flag_q  <= pfx_flag_d;
      ser_flag_q  <= ser_flag_d;
      copy_q      <= copy_d;
      chunk_q     <= chunk_d;
      pmatch_q    <= pmatch_d;
      name0_q     <= name0_d;
      bank_q      <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    sstore_q <= sstore_d;
  end

  bdm_ram #(
    .WIDTH (8),
    .DEPTH (2 ** ADDR_W)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.payload_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bdm_emit #(
    .NAME_LEN   (NAME_LEN),
    .SERIAL_LEN (SERIAL_LEN),
    .IDX_W      (IDX_W),
    .NL_W       (NL_W)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .flags_i     (job_flags),
    .name_len_i  (job_len),
    .bank_i      (bank_q),
    .serial_i    (sstore_d),
    .busy_o      (emit_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  `BDM_ASSERT_NEXT(a_final_clears, start, phase_q == PH_LEN && name_len_q == '0)
  `BDM_ASSERT_NOW(a_data_rem, phase_q == PH_DATA, rem_q != 8'h00)
  `BDM_ASSERT_NOW(a_name_len_max, 1'b1, name_len_q <= NL_W'(NAME_LEN))

endmodule

FILE: tb/tb_top.sv
// -----------------------------------------------------------------------------
// Advertising payload device matcher testbench
// Streams advertising payloads into the matcher byte by byte. A directed table
// comes first, then random payloads under several UUID settings. Every result
// is checked field by field, against an in-bench parser or, for typed directed
// rows, against the table's flags. Both handshakes idle at random, and the result
// side holds off once for a long stretch.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdm_pkg::*;

  localparam int NAME_LEN     = 16;
  localparam int SERIAL_LEN   = 6;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 200000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UUID_W0, REG_UUID_W1, REG_UUID_W2, REG_UUID_W3
  } cfg_reg_e;

  typedef enum logic [1:0] {WANT_LEN, WANT_TYPE, IN_DATA, STOPPED} parse_phase_e;
  typedef enum logic [1:0] {EL_OTHER, EL_UUID, EL_SHORT, EL_FULL} elem_kind_e;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       fin;
    logic       typed;
    bdm_flags_t flags;
  } dir_row_t;

  // Flags are typed in only for payloads whose report is obvious.
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    // Zero length byte right away.
    '{8'h00, 1'b1, 1'b1, 4'b1000},
    // Dangling length byte.
    '{8'hFF, 1'b1, 1'b1, 4'b0000},
    // Element cut short by the final byte.
    '{8'h03, 1'b0, 1'b0, 4'b0000},
    '{8'h09, 1'b0, 1'b0, 4'b0000},
    '{8'h61, 1'b1, 1'b1, 4'b0000},
    // Shortened name with a zero first byte, then a shortened name that
    // replaces it, then a lower case complete name that replaces both.
    '{8'h02, 1'b0, 1'b0, 4'b0000},
    '{8'h08, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'h04, 1'b0, 1'b0, 4'b0000},
    '{8'h08, 1'b0, 1'b0, 4'b0000},
    '{8'h41, 1'b0, 1'b0, 4'b0000},
    '{8'h4C, 1'b0, 1'b0, 4'b0000},
    '{8'h20, 1'b0, 1'b0, 4'b0000},
    '{8'h07, 1'b0, 1'b0, 4'b0000},
    '{8'h09, 1'b0, 1'b0, 4'b0000},
    '{8'h61, 1'b0, 1'b0, 4'b0000},
    '{8'h6C, 1'b0, 1'b0, 4'b0000},
    '{8'h2D, 1'b0, 1'b0, 4'b0000},
    '{8'h78, 1'b0, 1'b0, 4'b0000},
    '{8'h79, 1'b0, 1'b0, 4'b0000},
    '{8'h7A, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b1, 1'b0, 4'b0000},
    // Empty complete name, stop, and an ignored byte that is final.
    '{8'h01, 1'b0, 1'b0, 4'b0000},
    '{8'h09, 1'b0, 1'b0, 4'b0000},
    '{8'h00, 1'b0, 1'b0, 4'b0000},
    '{8'hFF, 1'b1, 1'b1, 4'b1000}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  bdm_in_t               in_i        = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  bdm_out_t              out_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  ble_advert_device_matcher_core #(
    .NAME_LEN  (NAME_LEN),
    .SERIAL_LEN(SERIAL_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10ns clk_i = 1'b1;
    #10ns clk_i = 1'b0;
  end

  // Parser state mirrored from the block.
  logic [31:0]  uuid_cfg [4];
  parse_phase_e phase;
  logic [7:0]   remaining;
  elem_kind_e   kind;
  logic [7:0]   position;
  logic [7:0]   name_mem [NAME_LEN];
  logic [4:0]   name_len;
  logic [7:0]   serial_sh [SERIAL_LEN];
  logic [7:0]   serial_mem [SERIAL_LEN];
  bit           uuid_f, prefix_f, serial_f, copy_f;
  bit           chunk_ok;
  logic [PFX_NUM-1:0] prefix_live;
  bit           overrun;

  bdm_out_t     report_chars [NAME_LEN];
  bit           report_ready;
  bdm_out_t     expected_chars [$];
  logic [7:0]   payload_q [$];

  int mismatches    = 0;
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  int calm_items    = 0;
  int hold_cnt      = 0;
  int ready_calm    = 0;

  function automatic void clear_run();
    phase       = WANT_LEN;
    remaining   = '0;
    kind        = EL_OTHER;
    position    = '0;
    name_len    = '0;
    uuid_f      = 1'b0;
    prefix_f    = 1'b0;
    serial_f    = 1'b0;
    copy_f      = 1'b0;
    chunk_ok    = 1'b0;
    prefix_live = '0;
    overrun     = 1'b0;
  endfunction

  function automatic void close_element();
    if (kind == EL_FULL && position >= SERIAL_LEN) begin
      serial_mem = serial_sh;
      serial_f   = 1'b1;
    end
    if ((kind == EL_FULL || kind == EL_SHORT) && prefix_live != '0) begin
      prefix_f = 1'b1;
    end
    phase = WANT_LEN;
  endfunction

  function automatic void parser_step(input logic [7:0] b, input logic fin);
    logic [7:0] n;
    logic [7:0] c;
    int         p;
    int         q;
    bit         ok;
    report_ready = 1'b0;
    case (phase)
      WANT_LEN: begin
        if (b == 8'h00) begin
          phase = STOPPED;
        end else begin
          remaining = b;
          phase     = WANT_TYPE;
        end
      end
      WANT_TYPE: begin
        n           = remaining - 8'd1;
        remaining   = n;
        position    = '0;
        chunk_ok    = 1'b0;
        prefix_live = '0;
        copy_f      = 1'b0;
        if (b == AD_UUID128_PART || b == AD_UUID128_ALL) kind = EL_UUID;
        else if (b == AD_NAME_SHORT) kind = EL_SHORT;
        else if (b == AD_NAME_COMPLETE) kind = EL_FULL;
        else kind = EL_OTHER;
        if (kind == EL_SHORT || kind == EL_FULL) begin
          for (int j = 0; j < PFX_NUM; j++) begin
            if (PFX_LEN[j] <= n) prefix_live[j] = 1'b1;
          end
          if (kind == EL_FULL || name_len == 0 || name_mem[0] == 8'h00) begin
            copy_f   = 1'b1;
            name_len = (n < NAME_LEN) ? n[4:0] : 5'(NAME_LEN);
          end
        end
        if (n == 8'h00) close_element();
        else phase = IN_DATA;
      end
      IN_DATA: begin
        p = position;
        if (kind == EL_UUID) begin
          q = p % 16;
          if (q == 0) chunk_ok = 1'b1;
          if (b != uuid_cfg[q / 4][8 * (q % 4) +: 8]) chunk_ok = 1'b0;
          if (q == 15 && chunk_ok) uuid_f = 1'b1;
        end else if (kind != EL_OTHER) begin
          if (copy_f && p < NAME_LEN) name_mem[p] = b;
          for (int j = 0; j < SERIAL_LEN - 1; j++) serial_sh[j] = serial_sh[j + 1];
          serial_sh[SERIAL_LEN - 1] = b;
          c = (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ? b - CASE_OFFSET : b;
          for (int j = 0; j < PFX_NUM; j++) begin
            if (p < PFX_LEN[j] && c != PFX_TEXT[j][8 * p +: 8]) prefix_live[j] = 1'b0;
          end
        end
        if (position != 8'hFF) position = position + 8'd1;
        remaining = remaining - 8'd1;
        if (remaining == 8'h00) close_element();
      end
      default: begin
      end
    endcase

    if (fin) begin
      if (phase == WANT_TYPE || phase == IN_DATA) overrun = 1'b1;
      ok = !overrun;
      for (int k = 0; k < NAME_LEN; k++) begin
        report_chars[k].parse_ok     = ok;
        report_chars[k].uuid_found   = ok && uuid_f;
        report_chars[k].prefix_found = ok && prefix_f;
        report_chars[k].serial_valid = ok && serial_f;
        report_chars[k].char_index   = 4'(k);
        report_chars[k].name_char    = (ok && k < name_len) ? name_mem[k] : 8'h00;
        report_chars[k].serial_char  = (ok && serial_f && k < SERIAL_LEN) ?
                                       serial_mem[k] : 8'h00;
        report_chars[k].run_end      = (k == NAME_LEN - 1);
      end
      report_ready = 1'b1;
      clear_run();
    end
  endfunction

  // Name element: mostly a known prefix in mixed case plus a tail.
  function automatic void add_name_element();
    logic [7:0] data [$];
    logic [7:0] ch;
    int         j;
    int         tail;
    if ($urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, PFX_NUM - 1);
      for (int i = 0; i < PFX_LEN[j]; i++) begin
        ch = PFX_TEXT[j][8 * i +: 8];
        if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) ch = ch + CASE_OFFSET;
        data.push_back(ch);
      end
      if ($urandom_range(0, 5) == 0) data[$urandom_range(0, data.size() - 1)] = $urandom;
      tail = $urandom_range(0, 12);
    end else begin
      tail = $urandom_range(0, 20);
    end
    repeat (tail) begin
      if ($urandom_range(0, 3) == 0) ch = $urandom;
      else ch = $urandom_range(8'h30, 8'h7A);
      data.push_back(ch);
    end
    if (data.size() > 0 && $urandom_range(0, 7) == 0) data[0] = 8'h00;
    payload_q.push_back(8'(data.size() + 1));
    payload_q.push_back($urandom_range(0, 1) ? AD_NAME_SHORT : AD_NAME_COMPLETE);
    foreach (data[i]) payload_q.push_back(data[i]);
  endfunction

  // UUID element: whole chunks that match, nearly match or are random, sometimes followed by extra bytes.
  function automatic void add_uuid_element();
    int         chunks;
    int         extra;
    int         mode;
    logic [7:0] chunk [16];
    chunks = ($urandom_range(0, 7) == 0) ? 0 : (($urandom_range(0, 3) == 0) ? 2 : 1);
    extra  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    payload_q.push_back(8'(16 * chunks + extra + 1));
    payload_q.push_back($urandom_range(0, 1) ? AD_UUID128_PART : AD_UUID128_ALL);
    repeat (chunks) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 16; i++) begin
        chunk[i] = (mode == 3) ? 8'($urandom) : uuid_cfg[i / 4][8 * (i % 4) +: 8];
      end
      if (mode == 2) chunk[$urandom_range(0, 15)] ^= 8'(1 << $urandom_range(0, 7));
      foreach (chunk[i]) payload_q.push_back(chunk[i]);
    end
    repeat (extra) payload_q.push_back($urandom);
  endfunction

  function automatic void add_other_element();
    int n;
    n = $urandom_range(0, 6);
    payload_q.push_back(8'(n + 1));
    payload_q.push_back($urandom);
    repeat (n) payload_q.push_back($urandom);
  endfunction

  function automatic void build_payload();
    int sel;
    int cut;
    payload_q.delete();
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      repeat ($urandom_range(1, 8)) payload_q.push_back($urandom);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: add_name_element();
          4, 5:       add_uuid_element();
          default:    add_other_element();
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        payload_q.push_back(8'h00);
        repeat ($urandom_range(0, 3)) payload_q.push_back($urandom);
      end
      // A broken payload ends early, in a length byte or inside an element.
      if (sel == 1 && payload_q.size() > 1) begin
        cut = $urandom_range(1, payload_q.size() - 1);
        payload_q = payload_q[0:cut - 1];
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input bdm_flags_t flags);
    int       gap;
    bdm_out_t row;
    if (!quiet) begin
      if (calm_items > 0) begin
        calm_items--;
      end else if ($urandom_range(0, 9) == 0) begin
        calm_items = $urandom_range(10, 30);
      end else if ($urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 15);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_i       <= '{payload_byte: b, final_byte: fin};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parser_step(b, fin);
    if (report_ready) begin
      for (int k = 0; k < NAME_LEN; k++) begin
        if (typed) begin
          row              = '0;
          row.parse_ok     = flags.ok;
          row.uuid_found   = flags.uuid;
          row.prefix_found = flags.prefix;
          row.serial_valid = flags.serial;
          row.char_index   = 4'(k);
          row.run_end      = (k == NAME_LEN - 1);
          expected_chars.push_back(row);
        end else begin
          expected_chars.push_back(report_chars[k]);
        end
      end
    end
  endtask

  task automatic send_payloads(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_payload();
      foreach (payload_q[i]) begin
        send_byte(payload_q[i], i == payload_q.size() - 1, 1'b0, '0);
      end
      sent += payload_q.size();
    end
  endtask

  // Stop sending and let every request drain before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (2 * NAME_LEN) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    uuid_cfg[idx] = val;
  endtask

  task automatic set_uuid(input logic [31:0] w0, input logic [31:0] w1,
                          input logic [31:0] w2, input logic [31:0] w3);
    write_reg(REG_UUID_W0, w0);
    write_reg(REG_UUID_W1, w1);
    write_reg(REG_UUID_W2, w2);
    write_reg(REG_UUID_W3, w3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void compare_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    bdm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        $error("result with none outstanding, char_index %0d", out_o.char_index);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        compare_field("parse_ok", want.parse_ok, out_o.parse_ok);
        compare_field("uuid_found", want.uuid_found, out_o.uuid_found);
        compare_field("prefix_found", want.prefix_found, out_o.prefix_found);
        compare_field("serial_valid", want.serial_valid, out_o.serial_valid);
        compare_field("char_index", want.char_index, out_o.char_index);
        compare_field("name_char", want.name_char, out_o.name_char);
        compare_field("serial_char", want.serial_char, out_o.serial_char);
        compare_field("run_end", want.run_end, out_o.run_end);
      end
    end
  end

  // Result side: short random stalls, calm stretches, and one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt      = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (quiet || ready_calm > 0) begin
      if (ready_calm > 0) ready_calm--;
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      ready_calm = $urandom_range(20, 60);
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_cnt = $urandom_range(0, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 4; i++) uuid_cfg[i] = UUID_RST[i];
    foreach (name_mem[i]) name_mem[i] = 8'h00;
    foreach (serial_sh[i]) serial_sh[i] = 8'h00;
    foreach (serial_mem[i]) serial_mem[i] = 8'h00;
    clear_run();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].pbyte, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].flags);
    end
    send_payloads(40);

    // All-zero UUID; the result side stalls while short payloads keep coming.
    drain();
    set_uuid('0, '0, '0, '0);
    long_hold_req = 1'b1;
    repeat (6) send_byte(8'h00, 1'b1, 1'b0, '0);
    send_payloads(35);

    drain();
    set_uuid('1, '1, '1, '1);
    send_payloads(30);

    drain();
    set_uuid($urandom, $urandom, $urandom, $urandom);
    quiet = 1'b1;
    send_payloads(35);

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/bdm_pkg.sv
hdl/bdm_ram.sv
hdl/bdm_emit.sv
hdl/ble_advert_device_matcher_core.sv
tb/tb_top.sv
